### sv/idxh_pkg.sv
package idxh_pkg;

    localparam int ID_W   = 8;
    localparam int INK_W  = 32;
    localparam int FUNC_W = 2;
    localparam int ST_W   = 2;
    localparam int OCC_W  = 9;
    localparam int NUM_IDS = 256;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_POP    = 2'd2;
    localparam logic [FUNC_W-1:0] FN_PEEK   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_ABSENT = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_FILL,
        S_DN_RL,
        S_DN_RR,
        S_DN_CMP,
        S_UP_RD,
        S_UP_CMP,
        S_FIN
    } t_state;

endpackage

### sv/idxh_in_if.sv
interface idxh_in_if;
    import idxh_pkg::*;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   elem_id;
    logic [INK_W-1:0]  key;
    modport source (output valid, func, elem_id, key, input ready);
    modport sink   (input valid, func, elem_id, key, output ready);
endinterface

### sv/idxh_out_if.sv
interface idxh_out_if;
    import idxh_pkg::*;
    logic             valid;
    logic             ready;
    logic [ID_W-1:0]  out_id;
    logic [INK_W-1:0] out_key;
    logic [ST_W-1:0]  status;
    logic [OCC_W-1:0] occupancy;
    modport source (output valid, out_id, out_key, status, occupancy, input ready);
    modport sink   (input valid, out_id, out_key, status, occupancy, output ready);
endinterface

### sv/idxh_ram.sv
module idxh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### sv/indexed_min_heap.sv
// channel | dir | handshake          | payload
// i_req   | in  | valid/ready        | func, elem_id, key
// o_rsp   | out | valid/ready        | out_id, out_key, status, occupancy
//
// one item at a time: accept, lookup, then on pop/remove a fetch of the last entry,
// then per level sifted down a left read, a right read and a compare and move, per level
// sifted up a parent read and a compare and move, and last the hand-over of the result.
// reset clears the id valid bits and the count at once; no clearing pass.
// a finished result waits in the output register; the next item is taken once it is loaded.
module indexed_min_heap #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    idxh_in_if.sink    i_req,
    idxh_out_if.source o_rsp
);
    import idxh_pkg::*;

    localparam int SW = $clog2(CAPACITY + 1);
    localparam int EW = ID_W + KEY_BITS;
    localparam int IDX_W = $clog2(NUM_IDS);

    t_state r_state, n_state;
    logic [FUNC_W-1:0]   r_func;
    logic [ID_W-1:0]     r_id;
    logic [KEY_BITS-1:0] r_key;
    logic [SW-1:0]       r_count, n_count;
    logic [SW-1:0]       r_hole, n_hole;
    logic [ID_W-1:0]     r_cur_id, n_cur_id;
    logic [KEY_BITS-1:0] r_cur_key, n_cur_key;
    logic [EW-1:0]       r_lc;
    logic [ID_W-1:0]     r_oid, n_oid;
    logic [INK_W-1:0]    r_okey, n_okey;
    logic [ST_W-1:0]     r_ost, n_ost;
    logic                r_ov;
    logic [ID_W-1:0]     r_rsp_id;
    logic [INK_W-1:0]    r_rsp_key;
    logic [ST_W-1:0]     r_rsp_st;
    logic [OCC_W-1:0]    r_rsp_occ;
    logic [NUM_IDS-1:0]  r_pv;

    logic            h_we;
    logic [SW-1:0]   h_waddr, h_raddr;
    logic [EW-1:0]   h_wdata, h_rd;
    logic            p_we;
    logic [IDX_W-1:0] p_waddr, p_raddr;
    logic [SW-1:0]   p_wdata, p_rd;
    logic            pv_we, pv_val;
    logic [IDX_W-1:0] pv_idx;
    logic            load_out;

    logic [SW:0]         lft, rgt;
    logic [ID_W-1:0]     rd_id, lc_id;
    logic [KEY_BITS-1:0] rd_key, lc_key;
    logic [SW-1:0]       slot;
    logic                lc_less, rc_less;

    idxh_ram #(.WIDTH(EW), .DEPTH(CAPACITY + 1)) u_heap (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rd)
    );

    idxh_ram #(.WIDTH(SW), .DEPTH(NUM_IDS)) u_pos (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rd)
    );

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_ov;
    assign o_rsp.out_id    = r_rsp_id;
    assign o_rsp.out_key   = r_rsp_key;
    assign o_rsp.status    = r_rsp_st;
    assign o_rsp.occupancy = r_rsp_occ;

    assign lft    = {r_hole, 1'b0};
    assign rgt    = {r_hole, 1'b1};
    assign rd_id  = h_rd[EW-1:KEY_BITS];
    assign rd_key = h_rd[KEY_BITS-1:0];
    assign lc_id  = r_lc[EW-1:KEY_BITS];
    assign lc_key = r_lc[KEY_BITS-1:0];
    assign lc_less = lc_key < r_cur_key;
    // right child wins only against the smaller of current and left
    assign rc_less = (rgt <= {1'b0, r_count}) &&
                     (lc_less ? (rd_key < lc_key) : (rd_key < r_cur_key));

    always_comb begin
        slot = '0;
        if (r_pv[r_id[IDX_W-1:0]] && p_rd != '0 && p_rd <= r_count) begin
            slot = p_rd;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_hole    = r_hole;
        n_cur_id  = r_cur_id;
        n_cur_key = r_cur_key;
        n_oid     = r_oid;
        n_okey    = r_okey;
        n_ost     = r_ost;
        h_we      = 1'b0;
        h_waddr   = r_hole;
        h_wdata   = {r_cur_id, r_cur_key};
        h_raddr   = SW'(1);
        p_we      = 1'b0;
        p_waddr   = r_cur_id[IDX_W-1:0];
        p_wdata   = r_hole;
        p_raddr   = i_req.elem_id[IDX_W-1:0];
        pv_we     = 1'b0;
        pv_val    = 1'b1;
        pv_idx    = r_cur_id[IDX_W-1:0];
        load_out  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_oid  = r_id;
                n_okey = '0;
                n_ost  = ST_OK;
                n_state = S_FIN;
                n_cur_id  = r_id;
                n_cur_key = r_key;
                case (r_func)
                    FN_INSERT: begin
                        if (slot != '0) begin
                            n_hole  = slot;
                            n_state = S_DN_RL;
                        end else if ({1'b0, r_count} >= (SW+1)'(CAPACITY)) begin
                            n_ost = ST_FULL;
                        end else begin
                            n_count = r_count + SW'(1);
                            n_hole  = r_count + SW'(1);
                            n_state = S_UP_RD;
                        end
                    end
                    FN_REMOVE: begin
                        if (slot == '0) begin
                            n_ost = ST_ABSENT;
                        end else begin
                            pv_we   = 1'b1;
                            pv_val  = 1'b0;
                            pv_idx  = r_id[IDX_W-1:0];
                            n_count = r_count - SW'(1);
                            n_hole  = slot;
                            if (slot != r_count) begin
                                h_raddr = r_count;
                                n_state = S_FILL;
                            end
                        end
                    end
                    default: begin
                        if (r_count == '0) begin
                            n_ost = ST_EMPTY;
                            n_oid = '0;
                        end else begin
                            n_oid  = rd_id;
                            n_okey = INK_W'(rd_key);
                            if (r_func == FN_POP) begin
                                pv_we   = 1'b1;
                                pv_val  = 1'b0;
                                pv_idx  = rd_id[IDX_W-1:0];
                                n_count = r_count - SW'(1);
                                n_hole  = SW'(1);
                                if (r_count != SW'(1)) begin
                                    h_raddr = r_count;
                                    n_state = S_FILL;
                                end
                            end
                        end
                    end
                endcase
            end
            S_FILL: begin
                // last entry moves into the hole
                n_cur_id  = rd_id;
                n_cur_key = rd_key;
                n_state   = S_DN_RL;
            end
            S_DN_RL: begin
                if (lft > {1'b0, r_count}) begin
                    n_state = S_UP_RD;
                end else begin
                    h_raddr = lft[SW-1:0];
                    n_state = S_DN_RR;
                end
            end
            S_DN_RR: begin
                h_raddr = rgt[SW-1:0];
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (rc_less || lc_less) begin
                    h_we    = 1'b1;
                    p_we    = 1'b1;
                    pv_we   = 1'b1;
                    h_wdata = rc_less ? h_rd : r_lc;
                    p_waddr = rc_less ? rd_id[IDX_W-1:0] : lc_id[IDX_W-1:0];
                    pv_idx  = p_waddr;
                    n_hole  = rc_less ? rgt[SW-1:0] : lft[SW-1:0];
                    n_state = S_DN_RL;
                end else begin
                    n_state = S_UP_RD;
                end
            end
            S_UP_RD: begin
                if (r_hole == SW'(1)) begin
                    h_we    = 1'b1;
                    p_we    = 1'b1;
                    pv_we   = 1'b1;
                    n_state = S_FIN;
                end else begin
                    h_raddr = r_hole >> 1;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                h_we  = 1'b1;
                p_we  = 1'b1;
                pv_we = 1'b1;
                if (r_cur_key < rd_key) begin
                    // parent moves down into the hole
                    h_wdata = h_rd;
                    p_waddr = rd_id[IDX_W-1:0];
                    pv_idx  = rd_id[IDX_W-1:0];
                    n_hole  = r_hole >> 1;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ov || o_rsp.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_pv    <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            if (pv_we) begin
                r_pv[pv_idx] <= pv_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_func <= i_req.func;
            r_id   <= i_req.elem_id;
            r_key  <= KEY_BITS'(i_req.key);
        end
        if (r_state == S_DN_RR) begin
            r_lc <= h_rd;
        end
        if (load_out) begin
            r_rsp_id  <= r_oid;
            r_rsp_key <= r_okey;
            r_rsp_st  <= r_ost;
            r_rsp_occ <= OCC_W'(r_count);
        end
        r_hole    <= n_hole;
        r_cur_id  <= n_cur_id;
        r_cur_key <= n_cur_key;
        r_oid     <= n_oid;
        r_okey    <= n_okey;
        r_ost     <= n_ost;
    end
endmodule

### tb/sv/heap_check.sv
module heap_check
    import idxh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    idxh_in_if         i_req,
    idxh_out_if        o_rsp,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [INK_W-1:0] key;
    } heap_entry_t;

    typedef struct packed {
        logic [ID_W-1:0]  out_id;
        logic [INK_W-1:0] out_key;
        logic [ST_W-1:0]  status;
        logic [OCC_W-1:0] occupancy;
    } heap_result_t;

    heap_entry_t  slots[1:NUM_IDS];
    int unsigned  slot_of[NUM_IDS];
    int unsigned  count;
    heap_result_t expected_q[$];
    int           fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_q.size();

    function automatic void place(int unsigned s, heap_entry_t e);
        slots[s] = e;
        slot_of[e.id] = s;
    endfunction

    function automatic void swap_slots(int unsigned a, int unsigned b);
        heap_entry_t t;
        t = slots[a];
        place(a, slots[b]);
        place(b, t);
    endfunction

    function automatic void sift_up(int unsigned s);
        while (s > 1 && slots[s].key < slots[s/2].key) begin
            swap_slots(s, s / 2);
            s = s / 2;
        end
    endfunction

    function automatic void sift_down(int unsigned s);
        int unsigned m;
        forever begin
            m = s;
            if (2*s <= count && slots[2*s].key < slots[m].key) m = 2*s;
            if (2*s+1 <= count && slots[2*s+1].key < slots[m].key) m = 2*s+1;
            if (m == s) break;
            swap_slots(s, m);
            s = m;
        end
    endfunction

    function automatic void fill_hole(int unsigned s);
        int unsigned last;
        last = count;
        count--;
        if (s != last) begin
            place(s, slots[last]);
            sift_down(s);
            sift_up(s);
        end
    endfunction

    function automatic heap_result_t heap_apply(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id,
                                                 logic [INK_W-1:0] key);
        heap_result_t r;
        heap_entry_t  e;
        int unsigned  s;
        r = '0;
        r.out_id = id;
        s = slot_of[id];
        if (s > count) s = 0;
        case (fn)
            FN_INSERT: begin
                if (s != 0) begin
                    slots[s].key = key;
                    sift_down(s);
                    sift_up(s);
                end else if (count >= NUM_IDS) begin
                    r.status = ST_FULL;
                end else begin
                    e.id = id;
                    e.key = key;
                    count++;
                    place(count, e);
                    sift_up(count);
                end
            end
            FN_REMOVE: begin
                if (s == 0) begin
                    r.status = ST_ABSENT;
                end else begin
                    slot_of[id] = 0;
                    fill_hole(s);
                end
            end
            default: begin
                if (count == 0) begin
                    r.status = ST_EMPTY;
                    r.out_id = '0;
                end else begin
                    r.out_id = slots[1].id;
                    r.out_key = slots[1].key;
                    if (fn == FN_POP) begin
                        slot_of[slots[1].id] = 0;
                        fill_hole(1);
                    end
                end
            end
        endcase
        r.occupancy = count[OCC_W-1:0];
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        fails++;
    endtask

    initial begin
        fails = 0;
        count = 0;
        foreach (slot_of[i]) slot_of[i] = 0;
    end

    always @(posedge i_clk) begin
        heap_result_t w;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready)
                expected_q.push_back(heap_apply(i_req.func, i_req.elem_id, i_req.key));
            if (o_rsp.valid && o_rsp.ready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected item", o_rsp.out_id, 0);
                end else begin
                    w = expected_q.pop_front();
                    if (o_rsp.out_id !== w.out_id) report("out_id", o_rsp.out_id, w.out_id);
                    if (o_rsp.out_key !== w.out_key) report("out_key", o_rsp.out_key, w.out_key);
                    if (o_rsp.status !== w.status) report("status", o_rsp.status, w.status);
                    if (o_rsp.occupancy !== w.occupancy)
                        report("occupancy", o_rsp.occupancy, w.occupancy);
                end
            end
        end
    end
endmodule

### tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import idxh_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_rsp;
    int   cycles;

    idxh_in_if  req_if();
    idxh_out_if rsp_if();

    indexed_min_heap u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    heap_check u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout");
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // receiver: random stalls, or a long hold-off while hold_rsp is set
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_if.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id, logic [INK_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.func    <= fn;
        req_if.elem_id <= id;
        req_if.key     <= key;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [INK_W-1:0] rand_key();
        case ($urandom_range(3))
            0: return $urandom_range(15);
            1: return 32'hFFFF_FFF0 | $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_items(int n);
        int fsel;
        for (int i = 0; i < n; i++) begin
            fsel = $urandom_range(99);
            if (fsel < 45) send(FN_INSERT, ID_W'($urandom), rand_key());
            else if (fsel < 65) send(FN_REMOVE, ID_W'($urandom), $urandom);
            else if (fsel < 88) send(FN_POP, ID_W'($urandom), $urandom);
            else send(FN_PEEK, ID_W'($urandom), $urandom);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.func    = FN_INSERT;
        req_if.elem_id = '0;
        req_if.key     = '0;
        hold_rsp       = 1'b0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty heap, absent id, extremes, equal keys, update, last-entry removal
        send(FN_POP, 8'h00, '0);
        send(FN_PEEK, 8'hFF, '0);
        send(FN_REMOVE, 8'h5A, '0);
        send(FN_INSERT, 8'hFF, 32'hFFFF_FFFF);
        send(FN_REMOVE, 8'hFF, '0);
        send(FN_INSERT, 8'h00, 32'h0);
        send(FN_INSERT, 8'hFF, 32'hFFFF_FFFF);
        send(FN_INSERT, 8'hAA, 32'h0);
        send(FN_INSERT, 8'h55, 32'h8000_0000);
        send(FN_PEEK, 8'h00, '0);
        send(FN_INSERT, 8'hFF, 32'h0000_0001);
        send(FN_INSERT, 8'h00, 32'hFFFF_FFFE);
        send(FN_REMOVE, 8'hAA, '0);
        send(FN_POP, 8'h00, '0);
        send(FN_POP, 8'h00, '0);
        send(FN_POP, 8'h00, '0);
        send(FN_POP, 8'h00, '0);
        drain();

        // fill all ids while the receiver holds off, then update and re-insert keys, then empty out
        hold_rsp = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_rsp = 1'b0;
            end
        join_none
        for (int i = 0; i < NUM_IDS; i++) send(FN_INSERT, i[7:0], rand_key());
        send(FN_INSERT, 8'h00, 32'h1234);
        for (int i = 0; i < 10; i++) begin
            send(FN_REMOVE, 8'(i * 7), '0);
            send(FN_INSERT, 8'h80, rand_key());
            send(FN_INSERT, 8'(i * 7), rand_key());
            send(FN_INSERT, 8'(i * 7 + 1), rand_key());
        end
        drain();
        for (int i = 0; i < 260; i++) send(FN_POP, ID_W'($urandom), $urandom);
        drain();

        send_idle_pct = 31; recv_idle_pct = 46;
        random_items(200);
        send_idle_pct = 46; recv_idle_pct = 31;
        random_items(200);
        drain();
        send_idle_pct = 0; recv_idle_pct = 0;
        random_items(140);
        drain();

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### indexed_min_heap.f
sv/idxh_pkg.sv
sv/idxh_in_if.sv
sv/idxh_out_if.sv
sv/idxh_ram.sv
sv/indexed_min_heap.sv
tb/sv/heap_check.sv
tb/sv/testbench.sv
